// File: rtl/core/box_blur_3x3_stream_top_defines.svh
// Assertion macros for the box blur block. Each use stands on a line of its own.
`ifndef BOX_BLUR_3X3_STREAM_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_STREAM_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BB3_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bb3_pkg.sv
package bb3_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MIN_WIDTH   = 2;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = ADDR_W + 1;
    localparam int HEIGHT_W    = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = 12;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(4096);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic       action;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       frame_end;
        logic       run_last;
    } res_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_PIX   = 2'd0,
        CMD_PRIME = 2'd1,
        CMD_FLUSH = 2'd2
    } cmd_kind_t;

    // One unit of work for the back part: a pixel, a window prime read or a drain step.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        rgba_t             pix;
        logic              emit_a;
        logic              emit_b;
        logic              left;
        logic              right;
        logic              top;
        logic              fend;
    } cmd_t;

endpackage

// File: rtl/core/bb3_front.sv
module bb3_front
    import bb3_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    cfg_clear,
    input  logic    pix_valid,
    output logic    pix_stall,
    input  pix_in_t pix_data,
    input  logic    q_full,
    output logic    push,
    output cmd_t    push_cmd
);

    logic [ADDR_W-1:0]   col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [ADDR_W-1:0]   drain_reg, drain_next;
    logic                pend_reg, pend_next;
    cmd_t                pend_cmd_reg, pend_cmd_next;

    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                accept;
    logic                pixel_ok;
    logic                flush_ok;
    logic                row_end;
    logic [ADDR_W-1:0]   d;
    logic                has_right;
    logic                fend;
    cmd_t                pix_cmd;
    cmd_t                flush_cmd;
    cmd_t                prime_cmd;

    always_comb
    begin
        if (cfg.width < WIDTH_W'(MIN_WIDTH))
        begin
            w_eff = WIDTH_W'(MIN_WIDTH);
        end
        else if (cfg.width > WIDTH_W'(MAX_WIDTH))
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = cfg.width;
        end
        h_eff = (cfg.height == '0) ? HEIGHT_W'(1) : cfg.height;
    end

    assign pix_stall = q_full || pend_reg;
    assign accept    = pix_valid && !pix_stall;
    assign pixel_ok  = !pix_data.action && (row_reg < h_eff);
    assign flush_ok  = pix_data.action && (row_reg >= h_eff);
    assign row_end   = (({1'b0, col_reg} + WIDTH_W'(1)) == w_eff);

    always_comb
    begin
        if ({1'b0, drain_reg} >= w_eff)
        begin
            d = ADDR_W'(w_eff - WIDTH_W'(1));
        end
        else
        begin
            d = drain_reg;
        end
    end

    assign has_right = (({1'b0, d} + WIDTH_W'(1)) < w_eff);
    assign fend      = (({1'b0, d} + WIDTH_W'(1)) == w_eff);

    always_comb
    begin
        pix_cmd.kind   = CMD_PIX;
        pix_cmd.addr   = col_reg;
        pix_cmd.pix    = '{alpha: pix_data.in_alpha, blue: pix_data.in_blue,
                           green: pix_data.in_green, red: pix_data.in_red};
        pix_cmd.emit_a = (row_reg != '0) && (col_reg != '0);
        pix_cmd.emit_b = (row_reg != '0) && row_end;
        pix_cmd.left   = (col_reg >= ADDR_W'(2));
        pix_cmd.right  = 1'b1;
        pix_cmd.top    = (row_reg >= HEIGHT_W'(2));
        pix_cmd.fend   = 1'b0;

        flush_cmd.kind   = CMD_FLUSH;
        flush_cmd.addr   = d + ADDR_W'(1);
        flush_cmd.pix    = '0;
        flush_cmd.emit_a = 1'b1;
        flush_cmd.emit_b = 1'b0;
        flush_cmd.left   = (d != '0);
        flush_cmd.right  = has_right;
        flush_cmd.top    = (h_eff >= HEIGHT_W'(2));
        flush_cmd.fend   = fend;

        // The first drain step needs two columns in the window, so column zero is read first.
        prime_cmd        = '0;
        prime_cmd.kind   = CMD_PRIME;
        prime_cmd.addr   = '0;
    end

    always_comb
    begin
        push          = 1'b0;
        push_cmd      = pix_cmd;
        pend_next     = pend_reg;
        pend_cmd_next = pend_cmd_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        drain_next    = drain_reg;

        priority if (pend_reg)
        begin
            push_cmd = pend_cmd_reg;
            push     = !q_full;
            if (!q_full)
            begin
                pend_next = 1'b0;
            end
        end
        else if (accept && pixel_ok)
        begin
            push     = 1'b1;
            push_cmd = pix_cmd;
        end
        else if (accept && flush_ok)
        begin
            push = 1'b1;
            if (d == '0)
            begin
                push_cmd      = prime_cmd;
                pend_next     = 1'b1;
                pend_cmd_next = flush_cmd;
            end
            else
            begin
                push_cmd = flush_cmd;
            end
        end

        priority if (cfg_clear)
        begin
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
        end
        else if (accept && pixel_ok)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + HEIGHT_W'(1);
            end
            else
            begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
        else if (accept && flush_ok)
        begin
            if (fend)
            begin
                col_next   = '0;
                row_next   = '0;
                drain_next = '0;
            end
            else
            begin
                drain_next = d + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_cmd_reg <= pend_cmd_next;
    end

endmodule

// File: rtl/core/bb3_queue.sv
module bb3_queue
    import bb3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic head_valid,
    output cmd_t head,
    input  logic pop
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/bb3_back.sv
module bb3_back
    import bb3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cmd_t q_head,
    output logic q_pop,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    localparam int DIV3_MUL   = 2731;
    localparam int DIV3_SHIFT = 13;
    localparam int PROD_W     = SUM_W + DIV3_SHIFT;

    typedef enum logic [2:0] {
        DIV_2 = 3'd0,
        DIV_3 = 3'd1,
        DIV_4 = 3'd2,
        DIV_6 = 3'd3,
        DIV_9 = 3'd4
    } div_t;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] sum;
        div_t                  div;
        logic [7:0]            alpha;
        logic                  fend;
        logic                  last;
    } emis_t;

    // Floor of x / 3 for x below 4096 by a reciprocal multiply.
    function automatic logic [SUM_W-1:0] div3(input logic [SUM_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(DIV3_MUL);
        return p[PROD_W-1:DIV3_SHIFT];
    endfunction

    rgba_t upper_mem  [MAX_WIDTH];
    rgba_t middle_mem [MAX_WIDTH];
    rgba_t rd_up_reg;
    rgba_t rd_mid_reg;
    rgba_t win_reg [3][3];

    logic  s1_v_reg;
    cmd_t  s1_cmd_reg;
    logic  pend_a_reg;
    logic  pend_b_reg;
    cmd_t  s2_cmd_reg;
    logic  s3_v_reg;
    emis_t s3_reg;
    logic  s4_v_reg;
    emis_t s4_reg;
    logic  out_v_reg;
    res_t  out_reg;

    logic  out_ready;
    logic  s4_ready;
    logic  s3_ready;
    logic  s2_fire;
    logic  s2_in_ready;
    logic  s1_adv;
    logic  s1_ready;

    logic  e_shift;
    logic  e_left;
    logic  e_right;
    logic  e_top;
    logic  e_bottom;
    rgba_t px [3][3];
    emis_t emis;
    emis_t div1;
    res_t  fin;

    assign out_ready   = !out_v_reg || !res_stall;
    assign s4_ready    = !s4_v_reg || out_ready;
    assign s3_ready    = !s3_v_reg || s4_ready;
    assign s2_fire     = s3_ready && (pend_a_reg || pend_b_reg);
    assign s2_in_ready = !(pend_a_reg || pend_b_reg)
                         || (s3_ready && !(pend_a_reg && pend_b_reg));
    assign s1_adv      = s1_v_reg && s2_in_ready;
    assign s1_ready    = !s1_v_reg || s2_in_ready;
    assign q_pop       = q_valid && s1_ready;

    // Line stores: read when a command enters, written when a pixel leaves the read stage.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_up_reg  <= upper_mem[q_head.addr];
            rd_mid_reg <= middle_mem[q_head.addr];
        end
        if (s1_adv && (s1_cmd_reg.kind == CMD_PIX))
        begin
            upper_mem[s1_cmd_reg.addr]  <= rd_mid_reg;
            middle_mem[s1_cmd_reg.addr] <= s1_cmd_reg.pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_cmd_reg <= q_head;
        end
        if (s1_adv)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd_up_reg;
            win_reg[1][2] <= rd_mid_reg;
            win_reg[2][2] <= (s1_cmd_reg.kind == CMD_PIX) ? s1_cmd_reg.pix : '0;
        end
    end

    // The second result at a row end sees the window moved one column left.
    always_comb
    begin
        e_shift  = !pend_a_reg;
        e_top    = s2_cmd_reg.top;
        if (pend_a_reg)
        begin
            e_left   = s2_cmd_reg.left;
            e_right  = s2_cmd_reg.right;
            e_bottom = (s2_cmd_reg.kind == CMD_PIX);
        end
        else
        begin
            e_left   = 1'b1;
            e_right  = 1'b0;
            e_bottom = 1'b1;
        end

        for (int i = 0; i < 3; i++)
        begin
            px[i][0] = e_shift ? win_reg[i][1] : win_reg[i][0];
            px[i][1] = e_shift ? win_reg[i][2] : win_reg[i][1];
            px[i][2] = e_shift ? '0 : win_reg[i][2];
            if (!e_left)
            begin
                px[i][0] = '0;
            end
            if (!e_right)
            begin
                px[i][2] = '0;
            end
        end
        if (!e_top)
        begin
            for (int j = 0; j < 3; j++)
            begin
                px[0][j] = '0;
            end
        end
        if (!e_bottom)
        begin
            for (int j = 0; j < 3; j++)
            begin
                px[2][j] = '0;
            end
        end

        emis.sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                emis.sum[0] = emis.sum[0] + SUM_W'(px[i][j].red);
                emis.sum[1] = emis.sum[1] + SUM_W'(px[i][j].green);
                emis.sum[2] = emis.sum[2] + SUM_W'(px[i][j].blue);
            end
        end

        unique case ({e_top, e_bottom})
            2'b00:
            begin
                emis.div = (e_left && e_right) ? DIV_3 : DIV_2;
            end
            2'b11:
            begin
                emis.div = (e_left && e_right) ? DIV_9 : DIV_6;
            end
            default:
            begin
                emis.div = (e_left && e_right) ? DIV_6 : DIV_4;
            end
        endcase

        emis.alpha = px[1][1].alpha;
        emis.fend  = pend_a_reg && s2_cmd_reg.fend;
        emis.last  = !pend_a_reg || !pend_b_reg;
    end

    // Division in two steps: halve, quarter, divide by three or by six, then a second third for nine.
    always_comb
    begin
        div1 = s3_reg;
        for (int k = 0; k < 3; k++)
        begin
            unique case (s3_reg.div)
                DIV_2:   div1.sum[k] = s3_reg.sum[k] >> 1;
                DIV_4:   div1.sum[k] = s3_reg.sum[k] >> 2;
                DIV_6:   div1.sum[k] = div3(s3_reg.sum[k] >> 1);
                DIV_3,
                DIV_9:   div1.sum[k] = div3(s3_reg.sum[k]);
                default: div1.sum[k] = s3_reg.sum[k];
            endcase
        end
    end

    always_comb
    begin
        logic [2:0][SUM_W-1:0] q;
        for (int k = 0; k < 3; k++)
        begin
            q[k] = (s4_reg.div == DIV_9) ? div3(s4_reg.sum[k]) : s4_reg.sum[k];
        end
        fin.out_red   = q[0][7:0];
        fin.out_green = q[1][7:0];
        fin.out_blue  = q[2][7:0];
        fin.out_alpha = s4_reg.alpha;
        fin.frame_end = s4_reg.fend;
        fin.run_last  = s4_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            pend_a_reg <= 1'b0;
            pend_b_reg <= 1'b0;
            s3_v_reg   <= 1'b0;
            s4_v_reg   <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_v_reg <= q_valid;
            end
            if (s1_adv)
            begin
                pend_a_reg <= s1_cmd_reg.emit_a;
                pend_b_reg <= s1_cmd_reg.emit_b;
            end
            else if (s2_fire)
            begin
                if (pend_a_reg)
                begin
                    pend_a_reg <= 1'b0;
                end
                else
                begin
                    pend_b_reg <= 1'b0;
                end
            end
            if (s3_ready)
            begin
                s3_v_reg <= s2_fire;
            end
            if (s4_ready)
            begin
                s4_v_reg <= s3_v_reg;
            end
            if (out_ready)
            begin
                out_v_reg <= s4_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_fire)
        begin
            s3_reg <= emis;
        end
        if (s4_ready && s3_v_reg)
        begin
            s4_reg <= div1;
        end
        if (out_ready && s4_v_reg)
        begin
            out_reg <= fin;
        end
    end

    assign res_valid = out_v_reg;
    assign res_data  = out_reg;

endmodule

// File: rtl/core/box_blur_3x3_stream_top.sv
// Channel  | Direction | Handshake            | Payload
// pix      | in        | pix_valid, pix_stall | pix_data (pixel or flush beat)
// res      | out       | res_valid, res_stall | res_data (blurred pixel beat)
// cfg      | in        | APB psel/penable     | width at 0x0, height at 0x4
//
// One input beat per clock while pix_stall is low; a four-entry command queue decouples counters and pipeline.
// A row end gives the back part two results to emit, so long rows can stall the input;
// the first drain step reads column zero ahead and holds the input until its drain step is queued.
// Reset clears all control state; the line stores are not cleared.
// A stalled result holds in the output register while earlier stages keep filling.
module box_blur_3x3_stream_top
    import bb3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  pix_in_t            pix_data,
    output logic               res_valid,
    input  logic               res_stall,
    output res_t               res_data
);

    cfg_t     cfg_reg;
    logic     cfg_wr;
    reg_idx_t reg_sel;
    logic     q_full;
    logic     push;
    cmd_t     push_cmd;
    logic     q_valid;
    cmd_t     q_head;
    logic     q_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= WIDTH_RESET;
            cfg_reg.height <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_WIDTH:  cfg_reg.width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: cfg_reg.height <= pwdata[HEIGHT_W-1:0];
                default:    cfg_reg.width  <= cfg_reg.width;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_WIDTH:  prdata = PDATA_W'(cfg_reg.width);
            REG_HEIGHT: prdata = PDATA_W'(cfg_reg.height);
            default:    prdata = '0;
        endcase
    end

    bb3_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_wr),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    bb3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    bb3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

// File: rtl/core/bb3_checker.sv
`include "box_blur_3x3_stream_top_defines.svh"

module bb3_props
    import bb3_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic pready,
    input logic res_valid,
    input logic res_stall,
    input res_t res_data
);

    `BB3_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid, "result beat dropped while stalled")
    `BB3_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res_data), "stalled result beat changed")
    `BB3_ASSERT_NOW(a_fend_last, res_valid && res_data.frame_end, res_data.run_last, "frame end on a beat that is not the last of its item")
    `BB3_ASSERT_NEXT(a_pair_back, res_valid && !res_stall && !res_data.run_last, res_valid, "second result of a row end did not follow at once")
    `BB3_ASSERT_NOW(a_pready, 1'b1, pready, "configuration port inserted a wait state")

endmodule

bind box_blur_3x3_stream_top bb3_props u_bb3_props (.*);

// File: sim/bb3_checker.sv
`timescale 1ns / 100ps

module bb3_checker
    import bb3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pix_valid,
    input  logic               pix_stall,
    input  pix_in_t            pix_data,
    input  logic               res_valid,
    input  logic               res_stall,
    input  res_t               res_data,
    output int                 fails,
    output int                 pending,
    output int                 n_results
);

    logic [31:0] upper_rows [MAX_WIDTH];
    logic [31:0] mid_rows [MAX_WIDTH];
    logic [31:0] win [9];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned drain_pos;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    res_t        blur_q [$];

    // Truncated mean over the in-frame part of a 3x3 window, centre at index 4.
    function automatic res_t blur_pixel(input logic [31:0] px [9], input bit l, input bit r,
                                        input bit t, input bit b, input bit fend,
                                        input bit last);
        res_t        o;
        int unsigned sum [3];
        int unsigned rows;
        int unsigned cols;
        int unsigned n;
        sum = '{0, 0, 0};
        rows = 0;
        for (int i = 0; i < 3; i++)
        begin
            if ((i == 0 && !t) || (i == 2 && !b))
                continue;
            rows++;
            for (int j = 0; j < 3; j++)
            begin
                if ((j == 0 && !l) || (j == 2 && !r))
                    continue;
                for (int k = 0; k < 3; k++)
                    sum[k] += (px[i*3+j] >> (8*k)) & 32'hFF;
            end
        end
        cols = 1 + l + r;
        n = rows * cols;
        if (n == 0)
            n = 1;
        o.out_red   = 8'(sum[0] / n);
        o.out_green = 8'(sum[1] / n);
        o.out_blue  = 8'(sum[2] / n);
        o.out_alpha = px[4][31:24];
        o.frame_end = fend;
        o.run_last  = last;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned d;
        int unsigned idx;
        bit          rend;
        bit          ok;
        logic [31:0] p [9];
        res_t        want;
        if (!rst_n)
        begin
            foreach (win[i])
                win[i] = '0;
            foreach (upper_rows[i])
            begin
                upper_rows[i] = '0;
                mid_rows[i] = '0;
            end
            col_pos = 0;
            row_pos = 0;
            drain_pos = 0;
            width_reg = 13'd4096;
            height_reg = 16'd4096;
            blur_q.delete();
            fails = 0;
            n_results = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (reg_idx_t'(paddr[2]) == REG_WIDTH)
                    width_reg = pwdata[12:0];
                else
                    height_reg = pwdata[15:0];
                col_pos = 0;
                row_pos = 0;
                drain_pos = 0;
            end
            w = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
            h = (height_reg == 0) ? 1 : height_reg;
            if (pix_valid && !pix_stall)
            begin
                if (!pix_data.action)
                begin
                    if (row_pos < h)
                    begin
                        c = col_pos;
                        r = row_pos;
                        for (int i = 0; i < 3; i++)
                        begin
                            win[i*3]   = win[i*3+1];
                            win[i*3+1] = win[i*3+2];
                        end
                        win[2] = upper_rows[c];
                        win[5] = mid_rows[c];
                        win[8] = {pix_data.in_alpha, pix_data.in_blue,
                                  pix_data.in_green, pix_data.in_red};
                        upper_rows[c] = mid_rows[c];
                        mid_rows[c] = win[8];
                        rend = (c + 1 == w);
                        if (r >= 1)
                        begin
                            if (c >= 1)
                                blur_q.push_back(blur_pixel(win, c >= 2, 1, r >= 2, 1, 0,
                                                            !rend));
                            if (rend)
                            begin
                                for (int i = 0; i < 3; i++)
                                begin
                                    p[i*3]   = win[i*3+1];
                                    p[i*3+1] = win[i*3+2];
                                    p[i*3+2] = '0;
                                end
                                blur_q.push_back(blur_pixel(p, 1, 0, r >= 2, 1, 0, 1));
                            end
                        end
                        if (rend)
                        begin
                            col_pos = 0;
                            row_pos = r + 1;
                        end
                        else
                            col_pos = c + 1;
                    end
                end
                else if (row_pos >= h)
                begin
                    d = (drain_pos >= w) ? w - 1 : drain_pos;
                    for (int j = 0; j < 3; j++)
                    begin
                        ok = (j != 0 || d >= 1) && (j != 2 || d + 1 < w);
                        idx = d + j - 1;
                        p[j]   = ok ? upper_rows[idx] : '0;
                        p[3+j] = ok ? mid_rows[idx] : '0;
                        p[6+j] = '0;
                    end
                    blur_q.push_back(blur_pixel(p, d >= 1, d + 1 < w, h >= 2, 0,
                                                d + 1 == w, 1));
                    if (d + 1 == w)
                    begin
                        col_pos = 0;
                        row_pos = 0;
                        drain_pos = 0;
                    end
                    else
                        drain_pos = d + 1;
                end
            end
            if (res_valid && !res_stall)
            begin
                n_results++;
                if (blur_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat %p", res_data);
                end
                else
                begin
                    want = blur_q.pop_front();
                    if (res_data.out_red !== want.out_red ||
                        res_data.out_green !== want.out_green ||
                        res_data.out_blue !== want.out_blue ||
                        res_data.out_alpha !== want.out_alpha ||
                        res_data.frame_end !== want.frame_end ||
                        res_data.run_last !== want.run_last)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch at result %0d: expected %p, got %p",
                                     n_results, want, res_data);
                    end
                end
            end
            pending = blur_q.size();
        end
    end

    initial
        pending = 0;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import bb3_pkg::*;
();

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               pix_valid;
    logic               pix_stall;
    pix_in_t            pix_data;
    logic               res_valid;
    logic               res_stall;
    res_t               res_data;
    int                 fails;
    int                 pending;
    int                 n_results;

    int send_idle_pct;
    int stall_pct;
    int hold_req;
    int hold_left;
    int beats;
    int frames;

    box_blur_3x3_stream_top i_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
    );

    bb3_checker i_checker (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .pready(pready), .paddr(paddr), .pwdata(pwdata), .pix_valid(pix_valid),
        .pix_stall(pix_stall), .pix_data(pix_data), .res_valid(res_valid),
        .res_stall(res_stall), .res_data(res_data), .fails(fails), .pending(pending),
        .n_results(n_results)
    );

    initial
        clk = 1'b0;
    always #6 clk = ~clk;

    // The receiver stalls at random, or for a whole requested hold-off stretch.
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [7:0] rand_comp();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pix_in_t rand_pixel(input logic act);
        pix_in_t b;
        b.action   = act;
        b.in_red   = rand_comp();
        b.in_green = rand_comp();
        b.in_blue  = rand_comp();
        b.in_alpha = rand_comp();
        return b;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    // Valid stays high so that back-to-back beats need no second assignment.
    task automatic send_beat(input pix_in_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_data <= b;
        do
            @(posedge clk);
        while (pix_stall);
        @(negedge clk);
        beats++;
    endtask

    task automatic drain_results();
        pix_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // One frame: cut >= 0 stops after that many pixels without draining.
    task automatic run_frame(input int wv, input int hv, input int cut, input bit noise);
        int ew;
        int eh;
        int total;
        drain_results();
        write_reg(REG_WIDTH, wv);
        write_reg(REG_HEIGHT, hv);
        ew = (wv[12:0] < 2) ? 2 : (wv[12:0] > MAX_WIDTH) ? MAX_WIDTH : wv[12:0];
        eh = (hv[15:0] == 0) ? 1 : hv[15:0];
        total = (cut >= 0) ? cut : ew * eh;
        if (noise)
            send_beat(rand_pixel(1'b1));
        for (int i = 0; i < total; i++)
        begin
            send_beat(rand_pixel(1'b0));
            if (noise && i == total / 2 && $urandom_range(3) == 0)
                drain_results();
        end
        if (cut < 0)
        begin
            for (int i = 0; i < ew; i++)
            begin
                if (noise && i == ew - 1)
                    send_beat(rand_pixel(1'b0));
                send_beat(rand_pixel(1'b1));
            end
            frames++;
        end
    endtask

    initial
    begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pix_valid = 1'b0;
        pix_data = '0;
        res_stall = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        hold_left = 0;
        beats = 0;
        frames = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset geometry, clamped width and height, extreme frames.
        for (int i = 0; i < 5; i++)
            send_beat(rand_pixel(1'b0));
        run_frame(0, 0, -1, 1);
        run_frame(1, 1, -1, 1);
        run_frame(3, 3, -1, 1);
        run_frame(2, 65535, 7, 0);
        run_frame(8191, 1, 200, 0);
        run_frame(4096, 2, 300, 0);

        // A long receiver hold-off with the sender running flat out.
        drain_results();
        @(posedge clk);
        hold_req = 400;
        @(negedge clk);
        run_frame(10, 4, -1, 0);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 82 : (ph == 3) ? 19 : 0;
            stall_pct = (ph == 2) ? 82 : (ph == 3) ? 19 : 0;
            while (beats < 600 + (ph + 1) * 225)
                run_frame($urandom_range(2, 10), $urandom_range(1, 6), -1,
                          $urandom_range(2) == 0);
        end
        drain_results();

        $display("Covered %0d frames and %0d input beats, %0d results checked,",
                 frames, beats, n_results);
        $display("with clamped geometry, ignored beats, hold-off and random idling.");
        if (fails == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/bb3_pkg.sv
rtl/core/bb3_front.sv
rtl/core/bb3_queue.sv
rtl/core/bb3_back.sv
rtl/core/box_blur_3x3_stream_top.sv
rtl/core/bb3_checker.sv
sim/bb3_checker.sv
sim/tb_top.sv
